/* hdl/fst_pkg.sv */
package fst_pkg;

  // Action codes carried by an input word.
  localparam logic [2:0] ACT_HDR_START = 3'd0;
  localparam logic [2:0] ACT_HDR_DONE  = 3'd1;
  localparam logic [2:0] ACT_FRAME     = 3'd2;
  localparam logic [2:0] ACT_SYNC      = 3'd3;
  localparam logic [2:0] ACT_STOP      = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERRS   = 2'd1;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration reset values.
  localparam logic [15:0] MAX_FRAMES_RST = 16'd63;
  localparam logic [4:0]  MAX_ERRS_RST   = 5'd3;

  // Expected sync pattern.
  localparam logic [23:0] SYNC_PATTERN = 24'h552D16;

  typedef struct packed {
    logic [2:0]  action;
    logic [23:0] sync_word;
  } fst_in_t;

  typedef struct packed {
    logic        receiving;
    logic        signal_lost;
    logic        sync_checked;
    logic        sync_ok;
    logic [5:0]  next_slot;
    logic [31:0] frame_number;
    logic [31:0] missed_syncs;
  } fst_out_t;

  // Word held in the input register, with the bit error count precomputed.
  typedef struct packed {
    logic       valid;
    logic [2:0] action;
    logic [4:0] err_cnt;
  } fst_stage_t;

  typedef struct packed {
    logic [15:0] max_frames;
    logic [4:0]  max_errs;
  } fst_cfg_t;

  // Number of set bits in one byte.
  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  // Number of bits in which a 24-bit word differs from the sync pattern.
  function automatic logic [4:0] sync_errors(input logic [23:0] w);
    logic [23:0] x;
    x = w ^ SYNC_PATTERN;
    return 5'(popcount8(x[7:0])) + 5'(popcount8(x[15:8])) + 5'(popcount8(x[23:16]));
  endfunction

endpackage

/* hdl/fst_stream_if.sv */
interface fst_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* hdl/fst_in_stage.sv */
module fst_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  fst_stream_if.sink          in_i,
  input  logic                adv_i,
  output fst_pkg::fst_stage_t stage_o
);

  logic       valid_q;
  logic [2:0] action_q;
  logic [4:0] err_cnt_q;
  logic       load;

  // The register takes a new word when empty or when its word moves on.
  assign in_i.ready = !valid_q || adv_i;
  assign load       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  // Payload with the sync mismatch count worked out on the way in.
  always_ff @(posedge clk_i) begin
    if (load) begin
      action_q  <= in_i.data.action;
      err_cnt_q <= fst_pkg::sync_errors(in_i.data.sync_word);
    end
  end

  assign stage_o.valid   = valid_q;
  assign stage_o.action  = action_q;
  assign stage_o.err_cnt = err_cnt_q;

endmodule

/* hdl/fst_track.sv */
module fst_track #(
  parameter int unsigned SYNC_INTERVAL = 21,
  parameter int unsigned RX_SLOTS      = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fst_pkg::fst_stage_t stage_i,
  input  fst_pkg::fst_cfg_t   cfg_i,
  output logic                adv_o,
  fst_stream_if.source        out_o
);

  localparam int unsigned RES_W  = $clog2(SYNC_INTERVAL);
  localparam int unsigned SLOT_W = $clog2(RX_SLOTS);
  localparam logic [RES_W-1:0]  RES_LAST  = RES_W'(SYNC_INTERVAL - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RX_SLOTS - 1);
  localparam logic [31:0]       INTERVAL  = 32'(SYNC_INTERVAL);

  // Tracking state. The distance to the last sync is kept directly, together
  // with its residue modulo the sync interval; the frame counter carries its
  // residue modulo the slot count.
  logic [31:0]       fc_q, fc_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [31:0]       since_q, since_d;
  logic [RES_W-1:0]  res_q, res_d;
  logic [31:0]       missed_q, missed_d;
  logic              rx_q, rx_d;

  logic              out_valid_q;
  fst_pkg::fst_out_t out_q, out_d;

  logic              take;
  logic              lost, checked, ok;
  logic [31:0]       since_inc;
  logic [RES_W-1:0]  res_inc;
  logic [31:0]       fc_inc;
  logic [SLOT_W-1:0] slot_inc;
  logic [7:0]        slot_ext;

  assign adv_o = !out_valid_q || out_o.ready;
  assign take  = stage_i.valid && adv_o;

  // Increments that keep the residues exact across a 32-bit wrap.
  always_comb begin
    since_inc = since_q + 32'd1;
    fc_inc    = fc_q + 32'd1;
    if (since_q == '1 || res_q == RES_LAST) begin
      res_inc = '0;
    end else begin
      res_inc = res_q + RES_W'(1);
    end
    if (fc_q == '1 || slot_q == SLOT_LAST) begin
      slot_inc = '0;
    end else begin
      slot_inc = slot_q + SLOT_W'(1);
    end
  end

  // Event handling.
  always_comb begin
    fc_d     = fc_q;
    slot_d   = slot_q;
    since_d  = since_q;
    res_d    = res_q;
    missed_d = missed_q;
    rx_d     = rx_q;
    lost     = 1'b0;
    checked  = 1'b0;
    ok       = 1'b0;
    case (stage_i.action)
      fst_pkg::ACT_HDR_START: begin
        fc_d     = '0;
        slot_d   = '0;
        since_d  = '0;
        res_d    = '0;
        missed_d = '0;
        rx_d     = 1'b1;
      end
      fst_pkg::ACT_FRAME: begin
        lost    = since_q >= {16'd0, cfg_i.max_frames};
        checked = res_q == '0;
        ok      = checked && (stage_i.err_cnt <= cfg_i.max_errs);
        if (lost) begin
          rx_d = 1'b0;
        end
        if (ok) begin
          // The last sync moves to this frame, one behind the new count.
          since_d = 32'd1;
          res_d   = RES_W'(1);
        end else begin
          since_d = since_inc;
          res_d   = res_inc;
        end
        if (checked && !ok) begin
          missed_d = missed_q + 32'd1;
        end
        fc_d   = fc_inc;
        slot_d = slot_inc;
      end
      fst_pkg::ACT_SYNC: begin
        if (rx_q) begin
          if (since_q > INTERVAL) begin
            since_d = 32'd1;
            res_d   = RES_W'(1);
          end
        end else begin
          rx_d     = 1'b1;
          fc_d     = 32'd1;
          slot_d   = SLOT_W'(1);
          since_d  = 32'd1;
          res_d    = RES_W'(1);
          missed_d = '0;
        end
      end
      fst_pkg::ACT_STOP: begin
        rx_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Result word.
  always_comb begin
    slot_ext           = 8'(slot_d);
    out_d.receiving    = rx_d;
    out_d.signal_lost  = lost;
    out_d.sync_checked = checked;
    out_d.sync_ok      = ok;
    out_d.next_slot    = lost ? 6'd0 : slot_ext[5:0];
    out_d.frame_number = fc_d;
    out_d.missed_syncs = missed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q        <= '0;
      slot_q      <= '0;
      since_q     <= '0;
      res_q       <= '0;
      missed_q    <= '0;
      rx_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        fc_q     <= fc_d;
        slot_q   <= slot_d;
        since_q  <= since_d;
        res_q    <= res_d;
        missed_q <= missed_d;
        rx_q     <= rx_d;
      end
      if (adv_o) begin
        out_valid_q <= stage_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

/* hdl/frame_sync_tracker_core.sv */
// Channel   Dir  Payload                     Word accepted when
// in_i      in   fst_pkg::fst_in_t           valid && ready
// out_o     out  fst_pkg::fst_out_t          valid && ready
// cfg       in   cfg_idx_i, cfg_data_i       cfg_we_i
//
// Every input word yields one result word, through the input register and then the result register.
// One word is accepted per cycle while the output is not stalled; the input register and result register
// form a two-stage pipeline, with the tracking state updated in the result stage.
// Reset clears the tracking counters and loads the configuration defaults.
// A stalled output holds its word; the pipeline then fills and ready drops.
module frame_sync_tracker_core #(
  parameter int unsigned SYNC_INTERVAL = 21,
  parameter int unsigned RX_SLOTS      = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  fst_stream_if.sink                       in_i,
  fst_stream_if.source                     out_o,
  input  logic                             cfg_we_i,
  input  logic [fst_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fst_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  fst_pkg::fst_cfg_t   cfg_q;
  fst_pkg::fst_stage_t stage;
  logic                adv;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_frames <= fst_pkg::MAX_FRAMES_RST;
      cfg_q.max_errs   <= fst_pkg::MAX_ERRS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fst_pkg::CFG_MAX_FRAMES: cfg_q.max_frames <= cfg_data_i;
        fst_pkg::CFG_MAX_ERRS:   cfg_q.max_errs   <= cfg_data_i[4:0];
        default: begin
        end
      endcase
    end
  end

  fst_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (adv),
    .stage_o (stage)
  );

  fst_track #(
    .SYNC_INTERVAL (SYNC_INTERVAL),
    .RX_SLOTS      (RX_SLOTS)
  ) u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage),
    .cfg_i   (cfg_q),
    .adv_o   (adv),
    .out_o   (out_o)
  );

endmodule

/* tb/frame_sync_tracker_core_tb.sv */
`timescale 1ns / 100ps

module frame_sync_tracker_core_tb;
  import fst_pkg::*;

  localparam int unsigned SYNC_INTERVAL = 21;
  localparam int unsigned RX_SLOTS      = 64;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned PHASE_WORDS   = 100;
  localparam int unsigned N_PHASES      = 8;
  localparam int unsigned IDLE_PCT      = 30;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  fst_stream_if #(.T(fst_in_t))  in_if ();
  fst_stream_if #(.T(fst_out_t)) out_if ();

  frame_sync_tracker_core #(
    .SYNC_INTERVAL(SYNC_INTERVAL),
    .RX_SLOTS     (RX_SLOTS)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Event words waiting for the driver, and status words the tracker owes us.
  fst_in_t  event_queue[$];
  fst_out_t status_queue[$];

  // Shadow of the tracker's registers and counters.
  logic [15:0] trk_max_frames;
  logic [4:0]  trk_max_errs;
  logic [31:0] trk_frames;
  logic [31:0] trk_last_sync;
  logic [31:0] trk_missed;
  logic        trk_rx;

  int unsigned n_queued;
  int unsigned n_accepted;
  int unsigned n_results;
  int unsigned n_errors;
  int unsigned n_frame_events;
  int unsigned n_checks;
  int unsigned n_sync_ok;
  int unsigned n_drops;
  int unsigned cycle_cnt;
  logic        in_taken;
  logic        calm;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Predict the status word for one event and advance the shadow state.
  function automatic fst_out_t track_event(input fst_in_t ev);
    fst_out_t    r;
    logic [31:0] since;
    logic        lost;
    logic        checked;
    logic        ok;
    lost    = 1'b0;
    checked = 1'b0;
    ok      = 1'b0;
    since   = trk_frames - trk_last_sync;
    case (ev.action)
      ACT_HDR_START: begin
        trk_frames    = '0;
        trk_last_sync = '0;
        trk_missed    = '0;
        trk_rx        = 1'b1;
      end
      ACT_FRAME: begin
        n_frame_events++;
        if (since >= {16'b0, trk_max_frames}) begin
          lost   = 1'b1;
          trk_rx = 1'b0;
        end
        if (since % SYNC_INTERVAL == 0) begin
          checked = 1'b1;
          if ($countones(ev.sync_word ^ SYNC_PATTERN) <= trk_max_errs) begin
            ok            = 1'b1;
            trk_last_sync = trk_frames;
          end else begin
            trk_missed = trk_missed + 1;
          end
        end
        trk_frames = trk_frames + 1;
      end
      ACT_SYNC: begin
        if (trk_rx) begin
          if (since > SYNC_INTERVAL) begin
            trk_last_sync = trk_frames - 1;
          end
        end else begin
          trk_rx        = 1'b1;
          trk_frames    = 32'd1;
          trk_last_sync = '0;
          trk_missed    = '0;
        end
      end
      ACT_STOP: begin
        trk_rx = 1'b0;
      end
      default: begin
      end
    endcase
    n_checks  += checked;
    n_sync_ok += ok;
    n_drops   += lost;
    r.receiving    = trk_rx;
    r.signal_lost  = lost;
    r.sync_checked = checked;
    r.sync_ok      = ok;
    r.next_slot    = lost ? 6'd0 : 6'(trk_frames % RX_SLOTS);
    r.frame_number = trk_frames;
    r.missed_syncs = trk_missed;
    return r;
  endfunction

  // Sync word within a chosen distance of the pattern, or now and then a random one.
  function automatic logic [23:0] frame_word();
    logic [23:0] w;
    int          k;
    int          top;
    int          b;
    top = (trk_max_errs + 2 > 24) ? 24 : trk_max_errs + 2;
    if ($urandom_range(0, 4) == 0) begin
      return 24'($urandom);
    end
    k = $urandom_range(0, top);
    w = SYNC_PATTERN;
    while ($countones(w ^ SYNC_PATTERN) < k) begin
      b = $urandom_range(0, 23);
      if (w[b] == SYNC_PATTERN[b]) begin
        w[b] = ~w[b];
      end
    end
    return w;
  endfunction

  task automatic push_event(input logic [2:0] action, input logic [23:0] word);
    fst_in_t ev;
    ev.action    = action;
    ev.sync_word = word;
    event_queue.push_back(ev);
    n_queued++;
  endtask

  // One reception: a start, frames with occasional sync events, and mostly a stop.
  task automatic add_session();
    int n_fr;
    push_event(($urandom_range(0, 2) == 0) ? ACT_SYNC : ACT_HDR_START, 24'($urandom));
    if ($urandom_range(0, 1) == 1) begin
      push_event(ACT_HDR_DONE, 24'($urandom));
    end
    n_fr = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 160) : $urandom_range(1, 70);
    for (int i = 0; i < n_fr; i++) begin
      if ($urandom_range(0, 14) == 0) begin
        push_event(ACT_SYNC, 24'($urandom));
      end
      push_event(ACT_FRAME, frame_word());
    end
    if ($urandom_range(0, 4) != 0) begin
      push_event(ACT_STOP, 24'($urandom));
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == CFG_MAX_FRAMES) begin
      trk_max_frames = data;
    end else if (idx == CFG_MAX_ERRS) begin
      trk_max_errs = data[4:0];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every queued event went in and its status word came back.
  task automatic drain();
    while (!(n_accepted == n_queued && status_queue.size() == 0)) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  // Driver: holds a word until it is taken, then offers the next one or idles.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || in_taken) begin
        if (event_queue.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_if.valid <= 1'b1;
          in_if.data  <= event_queue.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: predicts on every accepted event and checks every status word.
  always @(posedge clk_i) begin
    fst_out_t exp_w;
    fst_out_t got_w;
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d status words outstanding.",
               cycle_cnt, status_queue.size());
      $display("FAILURE");
      $finish;
    end
    in_taken = rst_ni && in_if.valid && in_if.ready;
    if (in_taken) begin
      status_queue.push_back(track_event(in_if.data));
      n_accepted++;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      got_w = out_if.data;
      n_results++;
      if (status_queue.size() == 0) begin
        if (n_errors < 10) begin
          $display("Unexpected status word %0d: %p", n_results, got_w);
        end
        n_errors++;
      end else begin
        exp_w = status_queue.pop_front();
        if (got_w.receiving    !== exp_w.receiving    ||
            got_w.signal_lost  !== exp_w.signal_lost  ||
            got_w.sync_checked !== exp_w.sync_checked ||
            got_w.sync_ok      !== exp_w.sync_ok      ||
            got_w.next_slot    !== exp_w.next_slot    ||
            got_w.frame_number !== exp_w.frame_number ||
            got_w.missed_syncs !== exp_w.missed_syncs) begin
          if (n_errors < 10) begin
            $display("Mismatch on status word %0d:", n_results);
            $display("  expected rx=%b lost=%b chk=%b ok=%b slot=%0d frame=%0d missed=%0d",
                     exp_w.receiving, exp_w.signal_lost, exp_w.sync_checked,
                     exp_w.sync_ok, exp_w.next_slot, exp_w.frame_number,
                     exp_w.missed_syncs);
            $display("  actual   rx=%b lost=%b chk=%b ok=%b slot=%0d frame=%0d missed=%0d",
                     got_w.receiving, got_w.signal_lost, got_w.sync_checked,
                     got_w.sync_ok, got_w.next_slot, got_w.frame_number,
                     got_w.missed_syncs);
          end
          n_errors++;
        end
      end
    end
  end

  // Stimulus: directed events under reset settings, then random receptions
  // under a series of settings that includes the register extremes.
  initial begin
    logic [15:0] max_frames_set[N_PHASES];
    logic [4:0]  max_errs_set[N_PHASES];
    int unsigned calm_phase;
    int unsigned phase_start;
    max_frames_set = '{16'd63, 16'd0, 16'd1, 16'd65535, 16'd21, 16'd42, 16'd64, 16'd7};
    max_errs_set   = '{5'd3, 5'd0, 5'd24, 5'd31, 5'd2, 5'd5, 5'd3, 5'd1};
    calm_phase = $urandom_range(1, N_PHASES - 1);

    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_MAX_FRAMES;
    cfg_data_i   = '0;
    calm         = 1'b0;
    in_taken     = 1'b0;
    cycle_cnt    = 0;
    n_queued     = 0;
    n_accepted   = 0;
    n_results    = 0;
    n_errors     = 0;
    trk_max_frames = MAX_FRAMES_RST;
    trk_max_errs   = MAX_ERRS_RST;
    trk_frames     = '0;
    trk_last_sync  = '0;
    trk_missed     = '0;
    trk_rx         = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: idle events, word extremes, the error limit edge, unknown codes.
    push_event(ACT_HDR_DONE, 24'h000000);
    push_event(ACT_FRAME, 24'hFFFFFF);
    push_event(3'd5, 24'h000000);
    push_event(3'd6, 24'hFFFFFF);
    push_event(3'd7, 24'h123456);
    push_event(ACT_SYNC, 24'h000000);
    push_event(ACT_SYNC, 24'hFFFFFF);
    push_event(ACT_HDR_START, 24'h000000);
    push_event(ACT_FRAME, SYNC_PATTERN);
    push_event(ACT_FRAME, 24'h000000);
    push_event(ACT_HDR_DONE, 24'hFFFFFF);
    push_event(ACT_HDR_START, 24'h000000);
    push_event(ACT_FRAME, SYNC_PATTERN ^ 24'h800101);
    push_event(ACT_HDR_START, 24'h000000);
    push_event(ACT_FRAME, SYNC_PATTERN ^ 24'h810101);
    push_event(ACT_STOP, 24'hFFFFFF);
    push_event(ACT_FRAME, 24'h000000);
    push_event(ACT_HDR_START, 24'h000000);
    push_event(ACT_FRAME, SYNC_PATTERN ^ 24'hFFFFFF);
    push_event(ACT_STOP, 24'h000000);
    drain();

    // Random receptions, one setting per phase; one phase runs without idling.
    for (int unsigned p = 1; p < N_PHASES; p++) begin
      cfg_write(CFG_MAX_FRAMES, max_frames_set[p]);
      cfg_write(CFG_MAX_ERRS, (16'($urandom) & 16'hFFE0) | 16'(max_errs_set[p]));
      calm <= (p == calm_phase);
      phase_start = n_queued;
      while (n_queued - phase_start < PHASE_WORDS) begin
        if ($urandom_range(0, 4) == 0) begin
          push_event(3'($urandom_range(0, 7)), 24'($urandom));
        end else begin
          add_session();
        end
      end
      drain();
    end

    repeat (10) @(negedge clk_i);
    n_errors += status_queue.size();
    $display("Ran %0d events (%0d frames) over %0d settings in %0d cycles.",
             n_accepted, n_frame_events, N_PHASES, cycle_cnt);
    $display("Sync positions checked: %0d, accepted: %0d, receptions dropped: %0d.",
             n_checks, n_sync_ok, n_drops);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
